FILE: hw/rtl/cau_pkg.sv
// cau_pkg: widths, opcode and status codes, payload and pipeline stage types
// for the complex arithmetic unit. No dependencies.
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int TOL_BITS  = 31;
  localparam int OP_W      = 4;
  localparam int STAT_W    = 2;

  // derived widths
  localparam int PROD_W = 2 * WORD_BITS;          // signed product
  localparam int SUM_W  = 2 * WORD_BITS + 1;      // signed sum of two products
  localparam int DEN_W  = 2 * WORD_BITS;          // squared modulus
  localparam int NUM_W  = (2 * WORD_BITS + FRAC_BITS > WORD_BITS + 2 * FRAC_BITS) ?
                          2 * WORD_BITS + FRAC_BITS : WORD_BITS + 2 * FRAC_BITS;
  localparam int NQ_W   = NUM_W + 2;              // 2*num + den
  localparam int DIV_W  = 2 * WORD_BITS + 1;      // 2*den
  localparam int QUO_W  = WORD_BITS + 2;          // quotient bits kept
  localparam int REM_W  = DIV_W + 1;
  localparam int TH_W   = DEN_W + TOL_BITS + FRAC_BITS;
  localparam int EQ_W   = WORD_BITS + TOL_BITS;

  localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
  localparam logic [OP_W-1:0] OP_NEG   = 4'd4;
  localparam logic [OP_W-1:0] OP_CONJ  = 4'd5;
  localparam logic [OP_W-1:0] OP_INV   = 4'd6;
  localparam logic [OP_W-1:0] OP_MODSQ = 4'd7;
  localparam logic [OP_W-1:0] OP_EQUAL = 4'd8;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DIV0 = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

  localparam logic signed [WORD_BITS-1:0] WMAX = $signed({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam logic signed [WORD_BITS-1:0] WMIN = $signed({1'b1, {(WORD_BITS-1){1'b0}}});

  typedef struct packed {
    logic [OP_W-1:0]             opcode;
    logic signed [WORD_BITS-1:0] a_real;
    logic signed [WORD_BITS-1:0] a_imag;
    logic signed [WORD_BITS-1:0] b_real;
    logic signed [WORD_BITS-1:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_real;
    logic signed [WORD_BITS-1:0] res_imag;
    logic                        equal_flag;
    logic [STAT_W-1:0]           status;
  } cau_out_t;

  typedef struct packed {
    logic [OP_W-1:0]             op;
    logic signed [WORD_BITS-1:0] ar;
    logic signed [WORD_BITS-1:0] ai;
    logic signed [WORD_BITS-1:0] br;
    logic signed [WORD_BITS-1:0] bi;
    logic signed [PROD_W-1:0]    m0;
    logic signed [PROD_W-1:0]    m1;
    logic signed [PROD_W-1:0]    m2;
    logic signed [PROD_W-1:0]    m3;
    logic signed [PROD_W-1:0]    m4;
    logic signed [PROD_W-1:0]    m5;
    logic                        eq;
  } s1_t;

  // operation info that rides along the whole pipe
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic                    eq;
    logic                    dz;
    logic signed [SUM_W-1:0] vre;
    logic signed [SUM_W-1:0] vim;
  } side_t;

  typedef struct packed {
    side_t            sd;
    logic [DEN_W-1:0] den;
  } s2_t;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] mag;
  } num_t;

  typedef struct packed {
    side_t            sd;
    logic [DEN_W-1:0] den;
    num_t             re;
    num_t             im;
  } s3_t;

  typedef struct packed {
    logic            neg;
    logic [NQ_W-1:0] n;
  } nq_t;

  typedef struct packed {
    side_t            sd;
    logic [DIV_W-1:0] d;
    nq_t              re;
    nq_t              im;
  } s4_t;

  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] nlo;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    side_t            sd;
    logic [DIV_W-1:0] d;
    lane_t            re;
    lane_t            im;
  } dst_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] val;
    logic                        sat;
  } clamp_t;

endpackage

FILE: hw/rtl/complex_arithmetic_unit_top.sv
// complex arithmetic unit: one item per cycle while the skid register is free;
// items pass stages 1 to 4, the divider entry and the restoring divider, one
// quotient bit per stage over WORD_BITS + 2 stages, then the output register.
// Throughput one item per clock unless stalled; an output skid register holds
// one result while the consumer stalls. Synchronous reset clears valids and
// the skid flag, sets tolerance=1. Depends on cau_pkg.
module complex_arithmetic_unit_top
  import cau_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cau_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cau_out_t            out_data,
  input  logic                cfg_wr_en,
  input  logic [TOL_BITS-1:0] cfg_wr_data
);

  logic [TOL_BITS-1:0] tol;

  logic en;
  logic v1, v2, v3, v4, vf;
  logic [QUO_W:0] dvalid;
  logic skid_full;

  s1_t      p1, p1_next;
  s2_t      p2, p2_next;
  s3_t      p3, p3_next;
  s4_t      p4, p4_next;
  dst_t     d0_next;
  dst_t     dpipe [QUO_W+1];
  cau_out_t res_q, res_next, skid_q;

  function automatic logic [SUM_W-1:0] abs_sum(logic signed [SUM_W-1:0] x);
    logic [SUM_W-1:0] r;
    r = x[SUM_W-1] ? $unsigned(-x) : $unsigned(x);
    return r;
  endfunction

  // round to nearest, ties away from zero, dropping the fraction bits
  function automatic logic signed [SUM_W-1:0] round_frac(logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] t;
    t = x + SUM_W'({1'b1, {(FRAC_BITS-1){1'b0}}}) - SUM_W'(x[SUM_W-1]);
    return t >>> FRAC_BITS;
  endfunction

  function automatic lane_t lane_start(nq_t n, logic [DIV_W-1:0] d);
    lane_t l;
    l.neg = n.neg;
    l.ovf = (NQ_W + DIV_W)'(n.n >> QUO_W) >= (NQ_W + DIV_W)'(d);
    l.rem = REM_W'(n.n >> QUO_W);
    l.nlo = n.n[QUO_W-1:0];
    l.quo = '0;
    return l;
  endfunction

  function automatic lane_t div_step(lane_t l, logic [DIV_W-1:0] d);
    lane_t            r;
    logic [REM_W-1:0] t;
    logic             ge;
    t  = {l.rem[DIV_W-1:0], l.nlo[QUO_W-1]};
    ge = t >= REM_W'(d);
    r      = l;
    r.rem  = ge ? t - REM_W'(d) : t;
    r.quo  = {l.quo[QUO_W-2:0], ge};
    r.nlo  = l.nlo << 1;
    return r;
  endfunction

  function automatic clamp_t clamp_sum(logic signed [SUM_W-1:0] v);
    clamp_t c;
    c.sat = 1'b0;
    c.val = WORD_BITS'(v);
    if (v > SUM_W'(WMAX)) begin
      c.sat = 1'b1;
      c.val = WMAX;
    end else if (v < SUM_W'(WMIN)) begin
      c.sat = 1'b1;
      c.val = WMIN;
    end
    return c;
  endfunction

  function automatic clamp_t clamp_lane(lane_t l);
    clamp_t           c;
    logic [QUO_W-1:0] lim;
    lim = l.neg ? QUO_W'({1'b1, {(WORD_BITS-1){1'b0}}}) : QUO_W'({(WORD_BITS-1){1'b1}});
    c.sat = l.ovf || (l.quo > lim);
    if (c.sat) begin
      c.val = l.neg ? WMIN : WMAX;
    end else begin
      c.val = l.neg ? -WORD_BITS'(l.quo) : WORD_BITS'(l.quo);
    end
    return c;
  endfunction

  // the pipe moves whenever the skid register is free
  assign en        = !skid_full;
  assign in_stall  = skid_full;
  assign out_valid = skid_full | vf;
  assign out_data  = skid_full ? skid_q : res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_BITS'(1);
    end else if (cfg_wr_en) begin
      tol <= cfg_wr_data;
    end
  end

  // stage 1: products and equality test
  always_comb begin
    logic signed [WORD_BITS-1:0] x, y;
    logic signed [WORD_BITS:0]   dr, di;
    logic [WORD_BITS:0]          mr, mi;
    x  = (in_data.opcode == OP_DIV) ? in_data.b_real : in_data.a_real;
    y  = (in_data.opcode == OP_DIV) ? in_data.b_imag : in_data.a_imag;
    dr = $signed({in_data.a_real[WORD_BITS-1], in_data.a_real})
       - $signed({in_data.b_real[WORD_BITS-1], in_data.b_real});
    di = $signed({in_data.a_imag[WORD_BITS-1], in_data.a_imag})
       - $signed({in_data.b_imag[WORD_BITS-1], in_data.b_imag});
    mr = dr[WORD_BITS] ? $unsigned(-dr) : $unsigned(dr);
    mi = di[WORD_BITS] ? $unsigned(-di) : $unsigned(di);
    p1_next.op = in_data.opcode;
    p1_next.ar = in_data.a_real;
    p1_next.ai = in_data.a_imag;
    p1_next.br = in_data.b_real;
    p1_next.bi = in_data.b_imag;
    p1_next.m0 = in_data.a_real * in_data.b_real;
    p1_next.m1 = in_data.a_imag * in_data.b_imag;
    p1_next.m2 = in_data.a_real * in_data.b_imag;
    p1_next.m3 = in_data.a_imag * in_data.b_real;
    p1_next.m4 = x * x;
    p1_next.m5 = y * y;
    p1_next.eq = (in_data.opcode == OP_EQUAL) &&
                 (EQ_W'(mr) < EQ_W'(tol)) && (EQ_W'(mi) < EQ_W'(tol));
  end

  // stage 2: sums of products, simple operations, squared modulus
  always_comb begin
    p2_next.sd.op  = p1.op;
    p2_next.sd.eq  = p1.eq;
    p2_next.sd.dz  = 1'b0;
    p2_next.den    = $unsigned(p1.m4) + $unsigned(p1.m5);
    case (p1.op) inside
      OP_ADD: begin
        p2_next.sd.vre = SUM_W'(p1.ar) + SUM_W'(p1.br);
        p2_next.sd.vim = SUM_W'(p1.ai) + SUM_W'(p1.bi);
      end
      OP_SUB: begin
        p2_next.sd.vre = SUM_W'(p1.ar) - SUM_W'(p1.br);
        p2_next.sd.vim = SUM_W'(p1.ai) - SUM_W'(p1.bi);
      end
      OP_MUL: begin
        p2_next.sd.vre = SUM_W'(p1.m0) - SUM_W'(p1.m1);
        p2_next.sd.vim = SUM_W'(p1.m2) + SUM_W'(p1.m3);
      end
      OP_DIV: begin
        p2_next.sd.vre = SUM_W'(p1.m0) + SUM_W'(p1.m1);
        p2_next.sd.vim = SUM_W'(p1.m3) - SUM_W'(p1.m2);
      end
      OP_NEG: begin
        p2_next.sd.vre = -SUM_W'(p1.ar);
        p2_next.sd.vim = -SUM_W'(p1.ai);
      end
      OP_CONJ, OP_INV: begin
        p2_next.sd.vre = SUM_W'(p1.ar);
        p2_next.sd.vim = -SUM_W'(p1.ai);
      end
      OP_MODSQ: begin
        p2_next.sd.vre = SUM_W'(p1.m4) + SUM_W'(p1.m5);
        p2_next.sd.vim = '0;
      end
      default: begin
        p2_next.sd.vre = '0;
        p2_next.sd.vim = '0;
      end
    endcase
  end

  // stage 3: rounding, numerator magnitudes, zero or below-tolerance divisor check
  always_comb begin
    p3_next.sd  = p2.sd;
    p3_next.den = p2.den;
    p3_next.sd.dz = (p2.den == '0) ||
                    (TH_W'(p2.den) < (TH_W'(tol) << FRAC_BITS));
    if (p2.sd.op == OP_MUL || p2.sd.op == OP_MODSQ) begin
      p3_next.sd.vre = round_frac(p2.sd.vre);
      p3_next.sd.vim = round_frac(p2.sd.vim);
    end
    p3_next.re.neg = p2.sd.vre[SUM_W-1];
    p3_next.im.neg = p2.sd.vim[SUM_W-1];
    if (p2.sd.op == OP_INV) begin
      p3_next.re.mag = NUM_W'(abs_sum(p2.sd.vre)) << (2 * FRAC_BITS);
      p3_next.im.mag = NUM_W'(abs_sum(p2.sd.vim)) << (2 * FRAC_BITS);
    end else begin
      p3_next.re.mag = NUM_W'(abs_sum(p2.sd.vre)) << FRAC_BITS;
      p3_next.im.mag = NUM_W'(abs_sum(p2.sd.vim)) << FRAC_BITS;
    end
  end

  // stage 4: rounding offset folded in, quotient = (2n + d) / 2d
  always_comb begin
    p4_next.sd     = p3.sd;
    p4_next.d      = DIV_W'(p3.den) << 1;
    p4_next.re.neg = p3.re.neg;
    p4_next.im.neg = p3.im.neg;
    p4_next.re.n   = (NQ_W'(p3.re.mag) << 1) + NQ_W'(p3.den);
    p4_next.im.n   = (NQ_W'(p3.im.mag) << 1) + NQ_W'(p3.den);
  end

  // divider entry: overflow check and starting remainder
  always_comb begin
    d0_next.sd = p4.sd;
    d0_next.d  = p4.d;
    d0_next.re = lane_start(p4.re, p4.d);
    d0_next.im = lane_start(p4.im, p4.d);
  end

  // last stage: select, clamp and status
  always_comb begin
    clamp_t cr, ci;
    dst_t   dl;
    dl = dpipe[QUO_W];
    cr = '0;
    ci = '0;
    res_next = '0;
    case (dl.sd.op) inside
      OP_ADD, OP_SUB, OP_MUL, OP_NEG, OP_CONJ, OP_MODSQ: begin
        cr = clamp_sum(dl.sd.vre);
        ci = clamp_sum(dl.sd.vim);
        res_next.res_real = cr.val;
        res_next.res_imag = ci.val;
        res_next.status   = (cr.sat || ci.sat) ? STAT_SAT : STAT_OK;
      end
      OP_DIV, OP_INV: begin
        if (dl.sd.dz) begin
          res_next.status = STAT_DIV0;
        end else begin
          cr = clamp_lane(dl.re);
          ci = clamp_lane(dl.im);
          res_next.res_real = cr.val;
          res_next.res_imag = ci.val;
          res_next.status   = (cr.sat || ci.sat) ? STAT_SAT : STAT_OK;
        end
      end
      OP_EQUAL: begin
        res_next.equal_flag = dl.sd.eq;
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
      dvalid <= '0;
      vf     <= 1'b0;
    end else if (en) begin
      v1     <= in_valid;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      dvalid <= {dvalid[QUO_W-1:0], v4};
      vf     <= dvalid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1       <= p1_next;
      p2       <= p2_next;
      p3       <= p3_next;
      p4       <= p4_next;
      dpipe[0] <= d0_next;
      for (int k = 1; k <= QUO_W; k++) begin
        dpipe[k].sd <= dpipe[k-1].sd;
        dpipe[k].d  <= dpipe[k-1].d;
        dpipe[k].re <= div_step(dpipe[k-1].re, dpipe[k-1].d);
        dpipe[k].im <= div_step(dpipe[k-1].im, dpipe[k-1].d);
      end
      res_q <= res_next;
    end
  end

  // skid register catches the result when the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) begin
        skid_full <= 1'b0;
      end
    end else if (vf && out_stall) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && vf && out_stall) begin
      skid_q <= res_q;
    end
  end

endmodule
